// ----- rtl/wall_span_rasterizer_defines.svh -----
// Assertion macros for the wall span rasteriser
`ifndef WALL_SPAN_RASTERIZER_DEFINES_SVH
`define WALL_SPAN_RASTERIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define WSR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wall span rasteriser check failed");
`define WSR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wall span rasteriser check failed");
`else
`define WSR_ASSERT_IMP(lbl, ante, cons)
`define WSR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/wsr_pkg.sv -----
// Shared constants, action codes and palette of the wall span rasteriser
package wsr_pkg;
   localparam int ACC_W     = 40;  // accumulator of the shared add unit
   localparam int DEN_W     = 18;  // holds 2 * run
   localparam int MUL_STEPS = 18;
   localparam int DIV_STEPS = ACC_W;
   localparam int CNT_W     = 6;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_STEP  = 2'd2;

   localparam logic [3:0] LAST_COLOR = 4'd8;

   // returns {red, green, blue}; indices past the named colours are white
   function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
      logic [23:0] c;
      case (idx)
         4'd0:    c = {8'd255, 8'd0,   8'd0};
         4'd1:    c = {8'd160, 8'd0,   8'd0};
         4'd2:    c = {8'd0,   8'd255, 8'd0};
         4'd3:    c = {8'd0,   8'd160, 8'd0};
         4'd4:    c = {8'd0,   8'd0,   8'd255};
         4'd5:    c = {8'd0,   8'd0,   8'd160};
         4'd6:    c = {8'd255, 8'd255, 8'd0};
         4'd7:    c = {8'd160, 8'd160, 8'd0};
         4'd8:    c = {8'd75,  8'd75,  8'd75};
         default: c = {8'd255, 8'd255, 8'd255};
      endcase
      return c;
   endfunction
endpackage

// ----- rtl/wsr_ram.sv -----
// Generic single-port RAM with registered read
module wsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ----- rtl/wall_span_rasterizer.sv -----
// Wall span rasteriser: trapezoid to pixels under a per-column coverage mask
//
// req_ channel carries one item per beat: tuser holds the action (clear mask,
// load wall, step). rsp_ channel returns exactly one beat per request beat:
// tuser flags whether a pixel is carried and whether the wall is finished.
// Per item: a pixel step reads the mask word, then modifies and writes it,
// then forms the result. A load or a column advance computes both column
// edges on one shared 40-bit adder: per edge a setup, 18 multiply steps, a
// prepare, 18 more multiply steps, a check, up to 40 restoring divide steps
// and a finish. A clear sweeps the mask RAM one column word a cycle.
// The shared adder and the single RAM port serialise this work; req_tready is
// high only while the sequencer idles. After reset the mask is swept clear
// with req_tready low. A finished result waits in the output register while
// rsp_tready is low; a further item is still taken and worked on, and holds
// its result until the output register frees up.
`include "wall_span_rasterizer_defines.svh"
module wall_span_rasterizer #(
   parameter int SCREEN_COLS = 160,
   parameter int SCREEN_ROWS = 120
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // left_x, right_x, bottom_first, bottom_second, top_first, top_second,
   // color_index, zero pad
   input  logic [103:0] req_tdata,
   input  logic [1:0]   req_tuser,  // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pixel_x, pixel_y, red, green, blue, zero pad
   output logic [39:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser   // pixel_valid, wall_done
);
   import wsr_pkg::*;

   localparam int CW = $clog2(SCREEN_COLS);
   localparam int RW = $clog2(SCREEN_ROWS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SETUP, S_MUL1, S_PREP2, S_MUL2, S_CHK, S_DIV, S_FIN,
      S_PIX, S_OUT
   } state_type;

   state_type state_ff;
   logic clr_rsp_ff;
   logic [CW-1:0] clr_addr_ff;
   logic wall_active_ff;
   logic [CW-1:0] start_col_ff, end_col_ff, col_ff;
   logic [RW-1:0] row_ff, bot_ff, top_ff;
   logic signed [15:0] origin_ff, bbase_ff, tbase_ff;
   logic signed [16:0] bdelta_ff, tdelta_ff;
   logic [DEN_W-1:0] den_ff;
   logic [3:0] color_ff;
   logic edge_ff, neg_ff, sgn_ff;
   logic [17:0] k_ff;
   logic [ACC_W-1:0] acc_ff, mcand_ff;
   logic [MUL_STEPS-1:0] mplier_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic pend_valid_ff, pend_white_ff;
   logic [CW-1:0] pend_x_ff;
   logic [RW-1:0] pend_y_ff;
   logic rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic [1:0] rsp_user_ff;

   // unpack request
   logic signed [15:0] in_lx, in_rx, in_bf, in_bs, in_tf, in_ts;
   logic [3:0] in_color;
   assign in_lx    = req_tdata[15:0];
   assign in_rx    = req_tdata[31:16];
   assign in_bf    = req_tdata[47:32];
   assign in_bs    = req_tdata[63:48];
   assign in_tf    = req_tdata[79:64];
   assign in_ts    = req_tdata[95:80];
   assign in_color = req_tdata[99:96];

   // load decode: order the ends, widths, clipped span
   logic swap;
   logic signed [15:0] xa, xb, ba, bb, ta, tb;
   logic signed [16:0] dx;
   logic [16:0] run;
   logic [CW-1:0] clip_a, clip_b;
   assign swap = in_lx > in_rx;
   assign xa = swap ? in_rx : in_lx;
   assign xb = swap ? in_lx : in_rx;
   assign ba = swap ? in_bs : in_bf;
   assign bb = swap ? in_bf : in_bs;
   assign ta = swap ? in_ts : in_tf;
   assign tb = swap ? in_tf : in_ts;
   assign dx = 17'(xb) - 17'(xa);
   assign run = (dx == 17'sd0) ? 17'd1 : 17'(dx);

   function automatic logic [CW-1:0] clip_col(input logic signed [15:0] x);
      logic [CW-1:0] r;
      if (x < 16'sd1) r = CW'(1);
      else if (32'(x) > SCREEN_COLS - 1) r = CW'(SCREEN_COLS - 1);
      else r = x[CW-1:0];
      return r;
   endfunction
   assign clip_a = clip_col(xa);
   assign clip_b = clip_col(xb);

   // shared adder
   logic [ACC_W-1:0] opa, opb, sum;
   logic inv;
   logic signed [15:0] base_sel;
   logic signed [16:0] delta_sel;
   assign base_sel  = edge_ff ? tbase_ff : bbase_ff;
   assign delta_sel = edge_ff ? tdelta_ff : bdelta_ff;

   always_comb begin
      opa = '0;
      opb = '0;
      inv = 1'b0;
      case (state_ff)
         S_SETUP: begin
            opa = ACC_W'(col_ff);
            opb = {{(ACC_W-16){origin_ff[15]}}, origin_ff};
            inv = 1'b1;
         end
         S_MUL1: begin
            opa = acc_ff;
            opb = mcand_ff;
         end
         S_MUL2: begin
            opa = acc_ff;
            opb = mcand_ff;
            inv = neg_ff;
         end
         S_DIV: begin
            opa = ACC_W'({rem_ff, acc_ff[ACC_W-1]});
            opb = ACC_W'(den_ff);
            inv = 1'b1;
         end
         default: begin
            opa = '0;
         end
      endcase
   end
   assign sum = opa + (inv ? ~opb : opb) + ACC_W'(inv);

   // mask RAM: one word of SCREEN_ROWS bits per column
   logic ram_we;
   logic [CW-1:0] ram_addr;
   logic [SCREEN_ROWS-1:0] ram_wdata, ram_rdata, row_bit;
   logic hit, border;
   assign row_bit  = SCREEN_ROWS'(1) << row_ff;
   assign hit      = |(ram_rdata & row_bit);
   assign ram_addr = (state_ff == S_CLEAR) ? clr_addr_ff : col_ff;
   assign ram_we   = (state_ff == S_CLEAR) || ((state_ff == S_PIX) && !hit);
   assign ram_wdata = (state_ff == S_CLEAR) ? '0 : (ram_rdata | row_bit);
   assign border = (col_ff == start_col_ff) || (col_ff == end_col_ff - CW'(1)) ||
                   (row_ff == bot_ff) || (row_ff == top_ff - RW'(1));

   wsr_ram #(.WIDTH(SCREEN_ROWS), .DEPTH(SCREEN_COLS)) u_mask (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // edge result, truncated quotient clipped to 1..SCREEN_ROWS-1
   logic [RW-1:0] edge_row;
   always_comb begin
      if (sgn_ff || acc_ff == '0) edge_row = RW'(1);
      else if (acc_ff >= ACC_W'(SCREEN_ROWS - 1)) edge_row = RW'(SCREEN_ROWS - 1);
      else edge_row = acc_ff[RW-1:0];
   end

   // result formatting
   logic [CW+7:0] x_ext;
   logic [RW+7:0] y_ext;
   logic [23:0] rgb;
   logic out_free;
   assign x_ext = {8'd0, pend_x_ff};
   assign y_ext = {8'd0, pend_y_ff};
   assign rgb = pend_white_ff ? 24'hFFFFFF : palette_rgb(color_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   logic [17:0] m_mag;
   assign m_mag = k_ff[16] ? {~k_ff[16:0], 1'b1} : {k_ff[16:0], 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_rsp_ff     <= 1'b0;
         clr_addr_ff    <= '0;
         wall_active_ff <= 1'b0;
         start_col_ff   <= '0;
         end_col_ff     <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         bot_ff         <= '0;
         top_ff         <= '0;
         origin_ff      <= '0;
         bbase_ff       <= '0;
         tbase_ff       <= '0;
         bdelta_ff      <= '0;
         tdelta_ff      <= '0;
         den_ff         <= DEN_W'(2);
         color_ff       <= '0;
         edge_ff        <= 1'b0;
         cnt_ff         <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // load the output register when a result is ready, drop it once taken
         if (state_ff == S_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               // sweep the mask one column word a cycle
               clr_addr_ff <= (clr_addr_ff == CW'(SCREEN_COLS - 1)) ?
                              '0 : clr_addr_ff + CW'(1);
               if (clr_addr_ff == CW'(SCREEN_COLS - 1)) begin
                  state_ff    <= clr_rsp_ff ? S_OUT : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  pend_valid_ff <= 1'b0;
                  case (req_tuser)
                     ACT_CLEAR: begin
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= S_CLEAR;
                     end
                     ACT_LOAD: begin
                        origin_ff      <= xa;
                        bbase_ff       <= ba;
                        tbase_ff       <= ta;
                        bdelta_ff      <= 17'(bb) - 17'(ba);
                        tdelta_ff      <= 17'(tb) - 17'(ta);
                        den_ff         <= {run, 1'b0};
                        color_ff       <= in_color;
                        start_col_ff   <= clip_a;
                        end_col_ff     <= clip_b;
                        col_ff         <= clip_a;
                        wall_active_ff <= clip_a < clip_b;
                        edge_ff        <= 1'b0;
                        state_ff       <= (clip_a < clip_b) ? S_SETUP : S_OUT;
                     end
                     ACT_STEP: begin
                        if (!wall_active_ff) begin
                           state_ff <= S_OUT;
                        end else if (row_ff < top_ff) begin
                           // mask word for col_ff is read this cycle
                           state_ff <= S_PIX;
                        end else begin
                           // advance one column
                           col_ff  <= col_ff + CW'(1);
                           edge_ff <= 1'b0;
                           if (col_ff + CW'(1) >= end_col_ff) begin
                              wall_active_ff <= 1'b0;
                              state_ff       <= S_OUT;
                           end else begin
                              state_ff <= S_SETUP;
                           end
                        end
                     end
                     default: begin
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_SETUP: begin
               // k = column - origin; first term base * 2run
               k_ff      <= sum[17:0];
               acc_ff    <= '0;
               mcand_ff  <= {{(ACC_W-16){base_sel[15]}}, base_sel};
               mplier_ff <= den_ff;
               cnt_ff    <= '0;
               state_ff  <= S_MUL1;
            end
            S_MUL1, S_MUL2: begin
               if (mplier_ff[0]) acc_ff <= sum;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               cnt_ff    <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
                  state_ff <= (state_ff == S_MUL1) ? S_PREP2 : S_CHK;
               end
            end
            S_PREP2: begin
               // second term delta * (2k+1), subtracted when 2k+1 is negative
               mcand_ff  <= {{(ACC_W-17){delta_sel[16]}}, delta_sel};
               mplier_ff <= m_mag;
               neg_ff    <= k_ff[16];
               cnt_ff    <= '0;
               state_ff  <= S_MUL2;
            end
            S_CHK: begin
               // negative numerator truncates to zero or below: row 1
               sgn_ff   <= acc_ff[ACC_W-1];
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= acc_ff[ACC_W-1] ? S_FIN : S_DIV;
            end
            S_DIV: begin
               if (!sum[ACC_W-1]) begin
                  rem_ff <= sum[DEN_W-1:0];
                  acc_ff <= {acc_ff[ACC_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[DEN_W-2:0], acc_ff[ACC_W-1]};
                  acc_ff <= {acc_ff[ACC_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!edge_ff) begin
                  bot_ff   <= edge_row;
                  edge_ff  <= 1'b1;
                  state_ff <= S_SETUP;
               end else begin
                  top_ff   <= edge_row;
                  row_ff   <= bot_ff;
                  state_ff <= S_OUT;
               end
            end
            S_PIX: begin
               pend_valid_ff <= !hit;
               pend_white_ff <= border || (color_ff > LAST_COLOR);
               pend_x_ff     <= col_ff;
               pend_y_ff     <= row_ff;
               row_ff        <= row_ff + RW'(1);
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_user_ff  <= {!wall_active_ff, pend_valid_ff};
                  rsp_data_ff  <= pend_valid_ff ?
                     {1'b0, rgb[7:0], rgb[15:8], rgb[23:16], y_ext[6:0], x_ext[7:0]} :
                     40'd0;
                  clr_rsp_ff   <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // the sequencer is busy in the cycle after it takes a beat
   `WSR_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // the mask is written only by the clearing sweep or a pixel update
   `WSR_ASSERT_IMP(a_mask_write_src, ram_we, state_ff == S_CLEAR || state_ff == S_PIX)
   // an emitted pixel never lies on the clipped-off first column or row
   `WSR_ASSERT_IMP(a_pixel_in_span, rsp_valid_ff && rsp_user_ff[0], rsp_data_ff[7:0] != 8'd0 && rsp_data_ff[14:8] != 7'd0)
endmodule
